/* design/tcfp_pkg.sv */
// Shared types and constants of the turnout command frame parser.
package tcfp_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_START = 8'h3C;  // '<'
	localparam logic [7:0] CH_END   = 8'h3E;  // '>'
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_H     = 8'h48;  // 'H'
	localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// result kinds
	typedef enum logic [2:0] {
		KIND_CLOSED    = 3'd0,
		KIND_THROWN    = 3'd1,
		KIND_TRACK_MGR = 3'd2,
		KIND_UNKNOWN   = 3'd3,
		KIND_EMPTY     = 3'd4,
		KIND_MALFORMED = 3'd5,
		KIND_BAD       = 3'd6
	} kind_t;

	// command token seen at the head of a frame
	typedef enum logic [1:0] {
		TK_NONE  = 2'd0,
		TK_H     = 2'd1,
		TK_EQ    = 2'd2,
		TK_OTHER = 2'd3
	} token_t;

	// configuration register indexes
	localparam logic [1:0] REG_MASK   = 2'd0;
	localparam logic [1:0] REG_CLOSED = 2'd1;
	localparam logic [1:0] REG_THROWN = 2'd2;

	localparam int MAG_W = 17;
	localparam logic [MAG_W-1:0] MAG_SAT = 17'd32768;
	localparam logic signed [15:0] ID_MAX = 16'sd63;

	// one decimal digit into a saturating magnitude
	function automatic logic [MAG_W-1:0] acc_digit(input logic [MAG_W-1:0] mag,
			input logic [7:0] c);
		logic [19:0] ext;
		logic [19:0] v;
		ext = {3'b000, mag};
		v = (ext << 3) + (ext << 1) + {16'h0000, c[3:0]};
		return (v > {3'b000, MAG_SAT}) ? MAG_SAT : v[MAG_W-1:0];
	endfunction

	// magnitude and sign to a saturated 16-bit value
	function automatic logic signed [15:0] fin_number(input logic [MAG_W-1:0] mag,
			input logic neg);
		logic [MAG_W-1:0] negated;
		negated = ~mag + 17'd1;
		if (neg)
			return negated[15:0];
		return (mag > 17'd32767) ? 16'sh7FFF : mag[15:0];
	endfunction

endpackage

/* design/turnout_command_frame_parser_unit.sv */
// Top level of the turnout command frame parser: byte register, parse state, result register.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+--------------------------------
//  in      | in_valid, in_ready, rx_byte               | one received character per item
//  out     | out_valid, out_ready, msg_kind,           | one classified result per frame
//          | turnout_id, requested_state               |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | mask, closed and thrown codes
//
// One item per cycle while no result is stalled: a byte is held in the input register,
// then the parse state and result register update from it.
// The parse state update for one byte is the recurrence that sets the one-cycle rate.
// Reset clears parse state, handshake state and the config registers (mask 0,
// closed 0, thrown 1). A stalled result holds the byte stage; in_ready drops only then.
module turnout_command_frame_parser_unit import tcfp_pkg::*; #(
	parameter int FRAME_CAPACITY = 128
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         msg_kind,
	output logic signed [15:0] turnout_id,
	output logic signed [15:0] requested_state,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	localparam int LEN_W = $clog2(FRAME_CAPACITY);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(FRAME_CAPACITY - 1);

	typedef enum logic [3:0] {
		PH_LEAD, PH_TOK, PH_TOKDONE, PH_PSKIP, PH_A_WS, PH_A_SIGN, PH_A_DIG,
		PH_B_WS, PH_B_SIGN, PH_B_DIG, PH_DONE, PH_FAIL
	} phase_t;

	// input stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;

	// config
	logic [63:0]        mask_q;
	logic signed [15:0] closed_q;
	logic signed [15:0] thrown_q;

	// parse state
	logic [LEN_W-1:0] len_q, len_d;
	phase_t           ph_q, ph_d, scan_ph;
	token_t           tok_q, tok_d;
	logic [MAG_W-1:0] n1_q, n1_d, n2_q, n2_d;
	logic             neg1_q, neg1_d, neg2_q, neg2_d, ended_q, ended_d;

	// result
	logic               out_valid_q;
	kind_t              kind_q, kind_d;
	logic signed [15:0] id_q, id_d, st_q, st_d;
	logic               emit, clear, parse_en;
	logic               is_ws, is_sign, is_digit, is_minus;
	logic signed [15:0] id_f, st_f;

	assign advance   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q   <= '0;
			closed_q <= 16'sd0;
			thrown_q <= 16'sd1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASK:   mask_q   <= cfg_data;
				REG_CLOSED: closed_q <= cfg_data[15:0];
				REG_THROWN: thrown_q <= cfg_data[15:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		is_ws    = byte_s1 inside {CH_SPACE, [CH_TAB:CH_CR]};
		is_sign  = (byte_s1 == CH_PLUS) || (byte_s1 == CH_MINUS);
		is_minus = (byte_s1 == CH_MINUS);
		is_digit = byte_s1 inside {[CH_ZERO:CH_NINE]};
	end

	// next parse state for the byte in the input stage
	always_comb begin
		len_d    = len_q;
		ph_d     = ph_q;
		tok_d    = tok_q;
		n1_d     = n1_q;
		n2_d     = n2_q;
		neg1_d   = neg1_q;
		neg2_d   = neg2_q;
		ended_d  = ended_q;
		emit     = 1'b0;
		clear    = 1'b0;
		parse_en = 1'b0;
		scan_ph  = (ph_q == PH_PSKIP) ? PH_A_WS : ph_q;

		if (byte_s1 == CH_START) begin
			clear = 1'b1;
		end else if (byte_s1 == CH_END) begin
			if (len_q != '0) begin
				clear = 1'b1;
				emit  = (ph_q != PH_LEAD);
			end
		end else if (byte_s1 != CH_CR && byte_s1 != CH_LF) begin
			if (len_q < LEN_LIMIT) begin
				len_d    = len_q + LEN_W'(1);
				parse_en = 1'b1;
			end else begin
				clear = 1'b1;
			end
		end

		if (parse_en && !ended_q) begin
			if (byte_s1 == CH_NUL) begin
				ended_d = 1'b1;
			end else begin
				case (ph_q)
					PH_LEAD: begin
						if (byte_s1 != CH_SPACE) begin
							tok_d = (byte_s1 == CH_H) ? TK_H :
								(byte_s1 == CH_EQ) ? TK_EQ : TK_OTHER;
							ph_d = PH_TOK;
						end
					end
					PH_TOK: begin
						if (byte_s1 == CH_SPACE) begin
							ph_d = (tok_q == TK_H) ? PH_PSKIP : PH_TOKDONE;
						end else begin
							tok_d = TK_OTHER;
							ph_d  = PH_TOKDONE;
						end
					end
					PH_TOKDONE, PH_DONE, PH_FAIL: ;
					default: begin
						// spaces before the first number stay in the skip phase
						if (!(ph_q == PH_PSKIP && byte_s1 == CH_SPACE)) begin
							ph_d = scan_ph;
							case (scan_ph)
								PH_A_WS: begin
									if (is_ws) begin
									end else if (is_sign) begin
										neg1_d = neg1_q | is_minus;
										ph_d   = PH_A_SIGN;
									end else if (is_digit) begin
										n1_d = acc_digit('0, byte_s1);
										ph_d = PH_A_DIG;
									end else begin
										ph_d = PH_FAIL;
									end
								end
								PH_A_SIGN: begin
									if (is_digit) begin
										n1_d = acc_digit('0, byte_s1);
										ph_d = PH_A_DIG;
									end else begin
										ph_d = PH_FAIL;
									end
								end
								PH_A_DIG: begin
									if (is_digit) begin
										n1_d = acc_digit(n1_q, byte_s1);
									end else if (is_ws) begin
										ph_d = PH_B_WS;
									end else if (is_sign) begin
										neg2_d = neg2_q | is_minus;
										ph_d   = PH_B_SIGN;
									end else begin
										ph_d = PH_FAIL;
									end
								end
								PH_B_WS: begin
									if (is_ws) begin
									end else if (is_sign) begin
										neg2_d = neg2_q | is_minus;
										ph_d   = PH_B_SIGN;
									end else if (is_digit) begin
										n2_d = acc_digit('0, byte_s1);
										ph_d = PH_B_DIG;
									end else begin
										ph_d = PH_FAIL;
									end
								end
								PH_B_SIGN: begin
									if (is_digit) begin
										n2_d = acc_digit('0, byte_s1);
										ph_d = PH_B_DIG;
									end else begin
										ph_d = PH_FAIL;
									end
								end
								PH_B_DIG: begin
									if (is_digit) begin
										n2_d = acc_digit(n2_q, byte_s1);
									end else begin
										ph_d = PH_DONE;
									end
								end
								default: ;
							endcase
						end
					end
				endcase
			end
		end

		if (clear) begin
			len_d   = '0;
			ph_d    = PH_LEAD;
			tok_d   = TK_NONE;
			n1_d    = '0;
			n2_d    = '0;
			neg1_d  = 1'b0;
			neg2_d  = 1'b0;
			ended_d = 1'b0;
		end
	end

	// classification of the frame that the end mark closes
	always_comb begin
		id_f   = fin_number(n1_q, neg1_q);
		st_f   = fin_number(n2_q, neg2_q);
		id_d   = 16'sd0;
		st_d   = 16'sd0;
		kind_d = KIND_UNKNOWN;
		if (tok_q == TK_EQ) begin
			kind_d = KIND_TRACK_MGR;
		end else if (tok_q != TK_H) begin
			kind_d = KIND_UNKNOWN;
		end else if (ph_q == PH_TOK || ph_q == PH_PSKIP) begin
			kind_d = KIND_EMPTY;
		end else if (ph_q != PH_B_DIG && ph_q != PH_DONE) begin
			kind_d = KIND_MALFORMED;
		end else begin
			id_d = id_f;
			st_d = st_f;
			if (id_f < 16'sd0 || id_f > ID_MAX || !mask_q[id_f[5:0]]) begin
				kind_d = KIND_BAD;
			end else if (st_f == closed_q) begin
				kind_d = KIND_CLOSED;
			end else if (st_f == thrown_q) begin
				kind_d = KIND_THROWN;
			end else begin
				kind_d = KIND_BAD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= '0;
			ph_q        <= PH_LEAD;
			tok_q       <= TK_NONE;
			n1_q        <= '0;
			n2_q        <= '0;
			neg1_q      <= 1'b0;
			neg2_q      <= 1'b0;
			ended_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				len_q   <= len_d;
				ph_q    <= ph_d;
				tok_q   <= tok_d;
				n1_q    <= n1_d;
				n2_q    <= n2_d;
				neg1_q  <= neg1_d;
				neg2_q  <= neg2_d;
				ended_q <= ended_d;
				out_valid_q <= emit;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind_q <= kind_d;
			id_q   <= id_d;
			st_q   <= st_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign msg_kind        = kind_q;
	assign turnout_id      = id_q;
	assign requested_state = st_q;

	a_ready_only_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (valid_s1 && out_valid_q && !out_ready))
		else $error("input stage blocked without an output stall");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LEN_LIMIT)
		else $error("frame length past capacity");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (kind_q <= KIND_BAD))
		else $error("result kind out of range");

	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_TRACK_MGR || kind_q == KIND_UNKNOWN ||
			kind_q == KIND_EMPTY || kind_q == KIND_MALFORMED)
		|-> (id_q == 16'sd0 && st_q == 16'sd0))
		else $error("unparsed frame carries nonzero fields");

	a_set_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_CLOSED || kind_q == KIND_THROWN)
		|-> (st_q == closed_q || st_q == thrown_q))
		else $error("set result state matches neither code");

endmodule

/* tb/sv/tb_turnout_command_frame_parser_unit.sv */
// Self-checking testbench of the turnout command frame parser: byte stream in, frame results out.
module tb_turnout_command_frame_parser_unit;
	import tcfp_pkg::*;

	localparam int FRAME_CAP = 128;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	typedef enum logic [3:0] {
		P_LEAD, P_TOKEN, P_TOKEN_END, P_PARAM_SKIP,
		P_ID_WS, P_ID_SIGN, P_ID_DIGITS,
		P_STATE_WS, P_STATE_SIGN, P_STATE_DIGITS,
		P_DONE, P_FAIL
	} scan_phase_t;

	typedef struct packed {
		kind_t              kind;
		logic signed [15:0] id;
		logic signed [15:0] st;
	} turnout_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         msg_kind;
	logic signed [15:0] turnout_id;
	logic signed [15:0] requested_state;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = '0;
	logic [63:0]        cfg_data = '0;

	// parser state as the block should hold it
	logic [63:0]        mask_r = '0;
	logic signed [15:0] closed_r = 16'sd0;
	logic signed [15:0] thrown_r = 16'sd1;
	int                 frm_len = 0;
	scan_phase_t        ph = P_LEAD;
	token_t             tok = TK_NONE;
	logic [16:0]        id_mag = '0;
	logic [16:0]        st_mag = '0;
	bit                 id_neg = 1'b0;
	bit                 st_neg = 1'b0;
	bit                 text_ended = 1'b0;

	logic [7:0]         bytes_to_send[$];
	turnout_result_t    results_due[$];
	int                 n_queued = 0;
	int                 n_bytes_sent = 0;
	int                 n_results_checked = 0;
	int                 n_cfg_sets = 0;
	int                 n_errors = 0;

	turnout_command_frame_parser_unit #(.FRAME_CAPACITY(FRAME_CAP)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.msg_kind(msg_kind),
		.turnout_id(turnout_id),
		.requested_state(requested_state),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 300000);
		$display("FAILURE");
		$finish;
	end

	// ---------------- prediction ----------------

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_num(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic [16:0] add_digit(input logic [16:0] mag, input logic [7:0] c);
		int v;
		v = int'(mag) * 10 + (int'(c) - int'(CH_ZERO));
		return (v > 32768) ? 17'd32768 : 17'(v);
	endfunction

	function automatic logic signed [15:0] to_value(input logic [16:0] mag, input bit neg);
		int m;
		m = int'(mag);
		if (neg)
			return 16'(-m);
		return (m > 32767) ? 16'sd32767 : 16'(m);
	endfunction

	function automatic void clear_frame();
		frm_len = 0;
		ph = P_LEAD;
		tok = TK_NONE;
		id_mag = '0;
		st_mag = '0;
		id_neg = 1'b0;
		st_neg = 1'b0;
		text_ended = 1'b0;
	endfunction

	// scanf-style reading of the two integers after "H "
	function automatic void scan_param(input logic [7:0] c);
		bit sgn;
		sgn = (c == CH_PLUS || c == CH_MINUS);
		case (ph)
		P_ID_WS: begin
			if (is_blank(c)) begin
			end else if (sgn) begin
				if (c == CH_MINUS) id_neg = 1'b1;
				ph = P_ID_SIGN;
			end else if (is_num(c)) begin
				id_mag = add_digit('0, c);
				ph = P_ID_DIGITS;
			end else begin
				ph = P_FAIL;
			end
		end
		P_ID_SIGN: begin
			if (is_num(c)) begin
				id_mag = add_digit('0, c);
				ph = P_ID_DIGITS;
			end else begin
				ph = P_FAIL;
			end
		end
		P_ID_DIGITS: begin
			if (is_num(c)) begin
				id_mag = add_digit(id_mag, c);
			end else if (is_blank(c)) begin
				ph = P_STATE_WS;
			end else if (sgn) begin
				if (c == CH_MINUS) st_neg = 1'b1;
				ph = P_STATE_SIGN;
			end else begin
				ph = P_FAIL;
			end
		end
		P_STATE_WS: begin
			if (is_blank(c)) begin
			end else if (sgn) begin
				if (c == CH_MINUS) st_neg = 1'b1;
				ph = P_STATE_SIGN;
			end else if (is_num(c)) begin
				st_mag = add_digit('0, c);
				ph = P_STATE_DIGITS;
			end else begin
				ph = P_FAIL;
			end
		end
		P_STATE_SIGN: begin
			if (is_num(c)) begin
				st_mag = add_digit('0, c);
				ph = P_STATE_DIGITS;
			end else begin
				ph = P_FAIL;
			end
		end
		P_STATE_DIGITS: begin
			if (is_num(c))
				st_mag = add_digit(st_mag, c);
			else
				ph = P_DONE;
		end
		default: begin
		end
		endcase
	endfunction

	function automatic void parse_char(input logic [7:0] c);
		if (text_ended)
			return;
		if (c == CH_NUL) begin
			text_ended = 1'b1;
			return;
		end
		case (ph)
		P_LEAD: begin
			if (c != CH_SPACE) begin
				if (c == CH_H)
					tok = TK_H;
				else if (c == CH_EQ)
					tok = TK_EQ;
				else
					tok = TK_OTHER;
				ph = P_TOKEN;
			end
		end
		P_TOKEN: begin
			if (c == CH_SPACE) begin
				ph = (tok == TK_H) ? P_PARAM_SKIP : P_TOKEN_END;
			end else begin
				tok = TK_OTHER;
				ph = P_TOKEN_END;
			end
		end
		P_TOKEN_END: begin
		end
		P_PARAM_SKIP: begin
			if (c != CH_SPACE) begin
				ph = P_ID_WS;
				scan_param(c);
			end
		end
		default: scan_param(c);
		endcase
	endfunction

	function automatic bit close_frame(output turnout_result_t r);
		logic signed [15:0] id;
		logic signed [15:0] st;
		r = '0;
		if (ph == P_LEAD)
			return 1'b0;
		if (tok == TK_EQ) begin
			r.kind = KIND_TRACK_MGR;
		end else if (tok != TK_H) begin
			r.kind = KIND_UNKNOWN;
		end else if (ph == P_TOKEN || ph == P_PARAM_SKIP) begin
			r.kind = KIND_EMPTY;
		end else if (ph != P_STATE_DIGITS && ph != P_DONE) begin
			r.kind = KIND_MALFORMED;
		end else begin
			id = to_value(id_mag, id_neg);
			st = to_value(st_mag, st_neg);
			r.id = id;
			r.st = st;
			if (id < 0 || id > ID_MAX || !mask_r[id[5:0]])
				r.kind = KIND_BAD;
			else if (st == closed_r)
				r.kind = KIND_CLOSED;
			else if (st == thrown_r)
				r.kind = KIND_THROWN;
			else
				r.kind = KIND_BAD;
		end
		return 1'b1;
	endfunction

	function automatic void predict_byte(input logic [7:0] c);
		turnout_result_t r;
		if (c == CH_START) begin
			clear_frame();
		end else if (c == CH_END) begin
			if (frm_len > 0) begin
				if (close_frame(r))
					results_due.push_back(r);
				clear_frame();
			end
		end else if (c != CH_CR && c != CH_LF) begin
			// a frame that runs full starts over
			if (frm_len < FRAME_CAP - 1) begin
				frm_len++;
				parse_char(c);
			end else begin
				clear_frame();
			end
		end
	endfunction

	// ---------------- handshakes ----------------

	function automatic int sender_idle_pct();
		if (n_bytes_sent < 450)
			return 33;
		if (n_bytes_sent < 900)
			return 48;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (n_bytes_sent < 450)
			return 48;
		if (n_bytes_sent < 900)
			return 33;
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= '0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(rx_byte);
				n_bytes_sent++;
			end
			if (!in_valid || in_ready) begin
				if (bytes_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct()) begin
					rx_byte <= bytes_to_send.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(input string what, input int want, input int got);
		n_errors++;
		$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin : result_check
		turnout_result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (results_due.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result, expected none, got kind %0d id %0d state %0d",
						$time, msg_kind, turnout_id, requested_state);
				end else begin
					want = results_due.pop_front();
					n_results_checked++;
					if (msg_kind !== want.kind)
						report_mismatch("msg_kind", int'(want.kind), int'(msg_kind));
					if (turnout_id !== want.id)
						report_mismatch("turnout_id", int'(want.id), int'(turnout_id));
					if (requested_state !== want.st)
						report_mismatch("requested_state", int'(want.st), int'(requested_state));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
		REG_MASK:   mask_r = val;
		REG_CLOSED: closed_r = val[15:0];
		REG_THROWN: thrown_r = val[15:0];
		default: begin
		end
		endcase
	endtask

	// hold the sender until every expected result is back, then let the pipe settle
	task automatic wait_drained();
		int guard;
		guard = 0;
		while ((bytes_to_send.size() != 0 || in_valid || results_due.size() != 0)
				&& guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (results_due.size() != 0 || bytes_to_send.size() != 0) begin
			n_errors++;
			$display("%0t: stream stuck, expected %0d results still due, got none", $time,
				results_due.size());
			results_due.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	// ---------------- stimulus ----------------

	task automatic put(input logic [7:0] c, input bit noisy = 1'b1);
		// stray line ends are dropped by the block anywhere in the stream
		if (noisy && $urandom_range(0, 59) == 0)
			bytes_to_send.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
		bytes_to_send.push_back(c);
		n_queued++;
	endtask

	task automatic put_text(input string s, input bit noisy = 1'b1);
		for (int i = 0; i < s.len(); i++)
			put(s[i], noisy);
	endtask

	function automatic logic [7:0] pick_blank();
		case ($urandom_range(0, 3))
		0: return CH_TAB;
		1: return CH_VT;
		2: return CH_FF;
		default: return CH_SPACE;
		endcase
	endfunction

	function automatic int pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 63);
		if (r < 78)
			return -int'($urandom_range(1, 70));
		if (r < 86)
			return $urandom_range(64, 40000);
		if (r < 94) begin
			case ($urandom_range(0, 5))
			0: return 32767;
			1: return 32768;
			2: return -32768;
			3: return -32769;
			4: return 64;
			default: return 0;
			endcase
		end
		return $urandom_range(100000, 99999999);
	endfunction

	function automatic int pick_state();
		int r;
		r = $urandom_range(0, 99);
		if (r < 38)
			return int'(closed_r);
		if (r < 76)
			return int'(thrown_r);
		if (r < 86) begin
			case ($urandom_range(0, 5))
			0: return -32768;
			1: return 32767;
			2: return 32768;
			3: return -32769;
			4: return -1;
			default: return 1;
			endcase
		end
		return int'($urandom_range(0, 80000)) - 40000;
	endfunction

	task automatic put_number(input int v, input bit need_sign);
		int mag;
		mag = (v < 0) ? -v : v;
		if (v < 0)
			put(CH_MINUS);
		else if (need_sign || $urandom_range(0, 7) == 0)
			put((v == 0 && $urandom_range(0, 1)) ? CH_MINUS : CH_PLUS);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 2)) put(CH_ZERO);
		put_text($sformatf("%0d", mag));
	endtask

	task automatic make_frame();
		int r;
		int id_v;
		int st_v;
		r = $urandom_range(0, 99);
		if (r < 8) begin
			// raw bytes of any value
			repeat ($urandom_range(2, 8)) put(8'($urandom_range(0, 255)), 1'b0);
			if ($urandom_range(0, 9) < 7)
				put(CH_END);
			return;
		end
		if (r < 12)
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(33, 126)));
		put(CH_START);
		repeat ($urandom_range(0, 2)) put(CH_SPACE);
		r = $urandom_range(0, 99);
		if (r < 74) begin
			put(CH_H);
		end else if (r < 82) begin
			put(CH_EQ);
		end else if (r < 88) begin
			put(CH_H);
			put(8'($urandom_range(33, 126)));
		end else if (r < 94) begin
			put(8'($urandom_range(33, 126)));
		end else begin
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(1, 255)));
		end
		if ($urandom_range(0, 99) < 88) begin
			put(CH_SPACE);
			repeat ($urandom_range(0, 1)) put(CH_SPACE);
			if ($urandom_range(0, 7) == 0)
				put(CH_TAB);
			id_v = pick_id();
			st_v = pick_state();
			put_number(id_v, 1'b0);
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 4) == 0) begin
					put_number(st_v, 1'b1);
				end else begin
					repeat ($urandom_range(1, 2)) put(pick_blank());
					put_number(st_v, 1'b0);
				end
				if ($urandom_range(0, 4) == 0) begin
					if ($urandom_range(0, 1))
						put(CH_SPACE);
					repeat ($urandom_range(1, 4)) put(8'($urandom_range(33, 126)));
				end
			end else if (r < 86) begin
				// state left out
			end else if (r < 93) begin
				put(CH_SPACE);
				put(8'($urandom_range(33, 126)));
				put_number(st_v, 1'b0);
			end else begin
				put(CH_NUL);
				put(CH_SPACE);
				put_number(st_v, 1'b0);
			end
		end
		// long tail that can run past the frame capacity
		if ($urandom_range(0, 99) < 5)
			repeat ($urandom_range(120, 135))
				put(($urandom_range(0, 10) == 10) ? CH_SPACE : 8'(CH_ZERO + $urandom_range(0, 9)));
		put(CH_END);
		if ($urandom_range(0, 99) < 3)
			put(CH_END);
	endtask

	initial begin : stimulus
		int seg_end;
		logic [15:0] eq_code;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int seg = 0; seg < 4; seg++) begin
			wait_drained();
			case (seg)
			0: begin
				write_reg(REG_MASK, {$urandom, $urandom} | 64'h8000_0000_0000_0001);
				write_reg(REG_CLOSED, 64'd0);
				write_reg(REG_THROWN, 64'd1);
			end
			1: begin
				write_reg(REG_MASK, '1);
				write_reg(REG_CLOSED, 64'hFFFF_FFFF_FFFF_8000);
				write_reg(REG_THROWN, 64'h0000_0000_0000_7FFF);
			end
			2: begin
				// closed and thrown share one value
				eq_code = 16'($urandom_range(0, 3));
				write_reg(REG_MASK, {$urandom, $urandom});
				write_reg(REG_CLOSED, {48'd0, eq_code});
				write_reg(REG_THROWN, {48'd0, eq_code});
			end
			default: begin
				write_reg(REG_MASK, '0);
				write_reg(REG_CLOSED, {$urandom, $urandom});
				write_reg(REG_THROWN, {$urandom, $urandom});
			end
			endcase
			n_cfg_sets++;
			if (seg == 0) begin
				put(8'hFF, 1'b0);
				put_text("<>", 1'b0);
				put_text("<  >", 1'b0);
				put_text("<H>", 1'b0);
				put_text("<=>", 1'b0);
				put_text("<Hx>", 1'b0);
				put_text("<H 63 1", 1'b0);
				put(CH_CR, 1'b0);
				put(CH_LF, 1'b0);
				put(CH_END, 1'b0);
				put(CH_START, 1'b0);
				put(CH_NUL, 1'b0);
				put(CH_END, 1'b0);
				put_text("<H 0 0>", 1'b0);
			end
			seg_end = n_queued + 330;
			while (n_queued < seg_end)
				make_frame();
		end
		wait_drained();
		repeat (4) @(posedge clk);
		$display("Streamed %0d bytes through the parser under %0d register settings,",
			n_bytes_sent, n_cfg_sets);
		$display("with %0d frame results checked field by field.", n_results_checked);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
